// ===== sv/ipss_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the incremental pi soft-start pwm core
package ipss_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned GAIN_W    = 31;
   localparam int unsigned RAMP_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned FRAC_W    = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_REFERENCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROPORTIONAL_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_UPPER_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LOWER_LIMIT = 3'd4;

   localparam logic signed [DATA_W-1:0] UPPER_LIMIT_RESET = 32'sd3276800;
   localparam logic [RAMP_W-1:0] RAMP_STEP = 16'd3;
   localparam logic [RAMP_W-1:0] RAMP_FULL = 16'd32768;
   localparam logic [7:0] COARSE_MIN = 8'd10;
   localparam logic [7:0] COARSE_MAX = 8'd190;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROP,
      ST_INTG,
      ST_SUM,
      ST_SCALE,
      ST_OUT
   } ipss_state_type;

   typedef enum logic [1:0] {
      MUL_PROP,
      MUL_INTG,
      MUL_SCALE
   } ipss_mul_sel_type;

   typedef struct packed {
      logic             load;
      logic             mul_en;
      ipss_mul_sel_type mul_sel;
      logic             acc_en;
      logic             sum_en;
      logic             commit;
      logic             out_load;
   } ipss_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ipss_stat_type;

endpackage

// ===== sv/ipss_dp.sv =====
`timescale 1ns / 1ps
// datapath: config registers, shared multiplier, pi state, ramp and output register
module ipss_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ipss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ipss_pkg::DATA_W-1:0]   csr_wdata,
   input  logic [ipss_pkg::DATA_W-1:0]   req_tdata,
   input  ipss_pkg::ipss_cmd_type        cmd,
   output ipss_pkg::ipss_stat_type       stat,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [55:0]                   rsp_tdata,
   output logic                          rsp_tuser
);

   logic signed [31:0] vref_ff, upper_ff, lower_ff;
   logic [30:0]        kp_ff, ki_ff;
   logic signed [31:0] prev_err_ff, prev_drive_ff;
   logic               ramp_active_ff, ramp_active_in;
   logic [15:0]        ramp_gain_ff, ramp_gain_in;
   logic signed [31:0] err_ff, diff_ff, acc_ff, y_ff, q_ff;
   logic signed [31:0] err_in;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] product;
   logic signed [31:0] y_clamp;
   logic [15:0]        whole;
   logic [7:0]         coarse;
   logic               rsp_valid_ff;
   logic [55:0]        rsp_data_ff;
   logic               rsp_user_ff;

   assign err_in = vref_ff - $signed(req_tdata);

   always_comb begin
      ramp_gain_in   = ramp_gain_ff;
      ramp_active_in = ramp_active_ff;
      if (ramp_active_ff) begin
         ramp_gain_in = ramp_gain_ff + ipss_pkg::RAMP_STEP;
      end
      if (ramp_gain_in >= ipss_pkg::RAMP_FULL) begin
         ramp_gain_in   = ipss_pkg::RAMP_FULL;
         ramp_active_in = 1'b0;
      end
   end

   always_comb begin
      unique case (cmd.mul_sel)
         ipss_pkg::MUL_PROP: begin
            mul_a = diff_ff;
            mul_b = $signed({1'b0, kp_ff});
         end
         ipss_pkg::MUL_INTG: begin
            mul_a = err_ff;
            mul_b = $signed({1'b0, ki_ff});
         end
         ipss_pkg::MUL_SCALE: begin
            mul_a = y_ff;
            mul_b = $signed({16'd0, ramp_gain_ff});
         end
         default: begin
            mul_a = y_ff;
            mul_b = $signed({16'd0, ramp_gain_ff});
         end
      endcase
   end

   assign product = mul_a * mul_b;

   always_comb begin
      priority if (y_ff >= upper_ff) begin
         y_clamp = upper_ff;
      end else if (y_ff <= lower_ff) begin
         y_clamp = lower_ff;
      end else begin
         y_clamp = y_ff;
      end
   end

   assign whole = q_ff[30:15];

   always_comb begin
      priority if (q_ff[31]) begin
         coarse = ipss_pkg::COARSE_MIN;
      end else if (whole >= {8'd0, ipss_pkg::COARSE_MAX}) begin
         coarse = ipss_pkg::COARSE_MAX;
      end else if (whole <= {8'd0, ipss_pkg::COARSE_MIN}) begin
         coarse = ipss_pkg::COARSE_MIN;
      end else begin
         coarse = whole[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff        <= '0;
         kp_ff          <= '0;
         ki_ff          <= '0;
         upper_ff       <= ipss_pkg::UPPER_LIMIT_RESET;
         lower_ff       <= '0;
         prev_err_ff    <= '0;
         prev_drive_ff  <= '0;
         ramp_active_ff <= 1'b1;
         ramp_gain_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ipss_pkg::CSR_VOLTAGE_REFERENCE:  vref_ff  <= $signed(csr_wdata);
               ipss_pkg::CSR_PROPORTIONAL_GAIN:  kp_ff    <= csr_wdata[30:0];
               ipss_pkg::CSR_INTEGRAL_GAIN:      ki_ff    <= csr_wdata[30:0];
               ipss_pkg::CSR_OUTPUT_UPPER_LIMIT: upper_ff <= $signed(csr_wdata);
               ipss_pkg::CSR_OUTPUT_LOWER_LIMIT: lower_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
         if (cmd.load) begin
            ramp_gain_ff   <= ramp_gain_in;
            ramp_active_ff <= ramp_active_in;
         end
         if (cmd.commit) begin
            prev_drive_ff <= y_clamp;
            prev_err_ff   <= err_ff;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff  <= err_in;
         diff_ff <= err_in - prev_err_ff;
      end
      if (cmd.mul_en) begin
         q_ff <= product[46:15];
      end
      if (cmd.acc_en) begin
         acc_ff <= prev_drive_ff + q_ff;
      end
      if (cmd.sum_en) begin
         y_ff <= acc_ff + q_ff;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {q_ff, q_ff[14:7], 8'd0, coarse};
         rsp_user_ff <= ~ramp_active_ff;
      end
   end

   assign stat.out_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_tuser     = rsp_user_ff;

endmodule

// ===== sv/ipss_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences the shared multiplier through one control step
module ipss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ipss_pkg::ipss_stat_type stat,
   output ipss_pkg::ipss_cmd_type  cmd
);

   ipss_pkg::ipss_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.mul_sel = ipss_pkg::MUL_PROP;
      unique case (state_ff)
         ipss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ipss_pkg::ST_PROP;
            end
         end
         ipss_pkg::ST_PROP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ipss_pkg::MUL_PROP;
            state_in    = ipss_pkg::ST_INTG;
         end
         ipss_pkg::ST_INTG: begin
            cmd.acc_en  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ipss_pkg::MUL_INTG;
            state_in    = ipss_pkg::ST_SUM;
         end
         ipss_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ipss_pkg::ST_SCALE;
         end
         ipss_pkg::ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ipss_pkg::MUL_SCALE;
            cmd.commit  = 1'b1;
            state_in    = ipss_pkg::ST_OUT;
         end
         ipss_pkg::ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ipss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ipss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/incremental_pi_soft_start_pwm_core.sv =====
`timescale 1ns / 1ps
// top level of the incremental pi soft-start pwm core
//
// req_ carries one signed q16.15 voltage sample per transaction. rsp_ returns one
// transaction per sample: the clamped pwm compare, its 8-bit fine fraction,
// the soft-start scaled drive and, on tuser, the ramp-done flag.
// csr_ writes the reference, gains and output limits, one register per cycle.
// an accepted sample passes the prop, intg, sum, scale and out states before
// rsp_tvalid; no new sample is taken until the core is back in idle. the one
// shared 32x32 multiplier serves the p, i and soft-start products in turn.
// reset clears the pi history, restarts the ramp from zero gain and loads
// the register reset values; no result is pending after reset.
// a result waits in the output register while rsp_tready is low; the next
// sample is still accepted and computed, and holds before its output stage
// until the waiting result is taken.
module incremental_pi_soft_start_pwm_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // measured_voltage
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // compare_coarse, compare_fine, scaled_drive
   output logic        rsp_tuser,   // ramp_finished
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   ipss_pkg::ipss_cmd_type  cmd;
   ipss_pkg::ipss_stat_type stat;

   ipss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ipss_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_coarse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] >= ipss_pkg::COARSE_MIN &&
                      rsp_tdata[7:0] <= ipss_pkg::COARSE_MAX))
      else $error("compare_coarse out of range");

   a_fine_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:8] == 8'd0))
      else $error("compare_fine low byte not zero");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sample accepted while a step is running");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_tvalid && req_tready))
      else $error("datapath load without input transaction");

endmodule
